// ===== hw/rtl/styled_thick_circle_rasterizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// stcr assertion macros
// shared concurrent assertion shorthands for the circle rasterizer
// ----------------------------------------------------------------------------
`ifndef STYLED_THICK_CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define STYLED_THICK_CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define STCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define STCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stcr_pkg.sv =====
// ----------------------------------------------------------------------------
// stcr package
// shared types and constants of the thick circle rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stcr_pkg;

   localparam int COORD_W     = 12;
   localparam int POINT_W     = 13;
   localparam int PATTERN_W   = 32;
   localparam int DASH_LEN_W  = 6;
   localparam int THICK_W     = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MIRROR_W    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MIRROR_W-1:0] MIRROR_FIRST = 3'd0;
   localparam logic [MIRROR_W-1:0] MIRROR_LAST  = 3'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DASH_PATTERN   = 2'd0,
      CSR_DASH_LENGTH    = 2'd1,
      CSR_RING_THICKNESS = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_STEP = 1'b1
   } mode_type;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // one step's work: either a column of eight mirrored points or a done answer
   typedef struct packed {
      logic               done;
      logic               visible;
      logic [POINT_W-1:0] walk_x;
      logic [POINT_W-1:0] walk_y;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
   } job_type;

endpackage

// ===== hw/rtl/stcr_front.sv =====
// ----------------------------------------------------------------------------
// stcr front
// holds settings and walk state, turns each step transaction into one job
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stcr_front #(
   parameter int DASH_MAX    = 32,
   parameter int THICK_MAX   = 16,
   parameter int RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stcr_pkg::csr_write_type       csr_write,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_mode,
   input  logic [stcr_pkg::COORD_W-1:0]  in_center_x,
   input  logic [stcr_pkg::COORD_W-1:0]  in_center_y,
   input  logic [RADIUS_BITS-1:0]        in_radius,
   output logic                          push_valid,
   input  logic                          push_ready,
   output stcr_pkg::job_type             push_job
);

   localparam int WALK_W = RADIUS_BITS + 2;
   localparam int DEC_W  = RADIUS_BITS + 6;
   localparam int OFS_W  = $clog2(THICK_MAX + 1) + 2;
   localparam int DIDX_W = (DASH_MAX > 1) ? $clog2(DASH_MAX) : 1;
   localparam int LEN_W  = 7;

   localparam logic signed [OFS_W-1:0]  OFS_ONE  = OFS_W'(1);
   localparam logic signed [WALK_W-1:0] WALK_ONE = WALK_W'(1);
   localparam logic signed [DEC_W-1:0]  DEC_ZERO = DEC_W'(0);
   localparam logic signed [DEC_W-1:0]  DEC_SIX  = DEC_W'(6);
   localparam logic signed [DEC_W-1:0]  DEC_TEN  = DEC_W'(10);
   localparam logic signed [DEC_W-1:0]  DEC_INIT = DEC_W'(3);
   localparam logic [LEN_W-1:0]         LEN_ONE  = LEN_W'(1);
   localparam logic [LEN_W-1:0]         LEN_MAX  = LEN_W'(DASH_MAX);
   localparam logic [LEN_W-1:0]         PAT_BITS = LEN_W'(stcr_pkg::PATTERN_W);
   localparam logic [5:0]               THICK_LIM = 6'(THICK_MAX);

   // settings
   logic [stcr_pkg::PATTERN_W-1:0]  dash_pattern_ff, dash_pattern_in;
   logic [stcr_pkg::DASH_LEN_W-1:0] dash_length_ff, dash_length_in;
   logic [stcr_pkg::THICK_W-1:0]    ring_thickness_ff, ring_thickness_in;

   // figure state
   logic [stcr_pkg::COORD_W-1:0] center_x_ff, center_x_in;
   logic [stcr_pkg::COORD_W-1:0] center_y_ff, center_y_in;
   logic [RADIUS_BITS-1:0]       base_radius_ff, base_radius_in;
   logic signed [OFS_W-1:0]      ring_offset_ff, ring_offset_in;
   logic signed [WALK_W-1:0]     walk_x_ff, walk_x_in;
   logic signed [WALK_W-1:0]     walk_y_ff, walk_y_in;
   logic signed [DEC_W-1:0]      decision_ff, decision_in;
   logic [DIDX_W-1:0]            dash_index_ff, dash_index_in;
   logic                         ring_started_ff, ring_started_in;
   logic                         active_ff, active_in;

   logic                     accept;
   logic                     walking;
   logic                     ring_end;
   logic [5:0]               thick_eff;
   logic signed [OFS_W-1:0]  half_thick;
   logic signed [OFS_W-1:0]  first_ofs;
   logic signed [OFS_W-1:0]  last_ofs;
   logic signed [OFS_W-1:0]  last_p1;
   logic signed [OFS_W-1:0]  neg_base;
   logic signed [OFS_W-1:0]  ofs_a;
   logic signed [OFS_W-1:0]  ofs_b;
   logic signed [WALK_W-1:0] r_try;
   logic signed [WALK_W-1:0] r_ring;
   logic                     ring_ok;
   logic signed [DEC_W-1:0]  d_init;
   logic signed [WALK_W-1:0] x_nx;
   logic signed [WALK_W-1:0] y_nx;
   logic signed [DEC_W-1:0]  xs;
   logic signed [DEC_W-1:0]  ys;
   logic signed [DEC_W-1:0]  d_nx;
   logic                     dec_pos;
   logic [LEN_W-1:0]         len_eff;
   logic [LEN_W-1:0]         idx_eff;
   logic [LEN_W-1:0]         idx_inc;
   logic [LEN_W-1:0]         idx_nx;
   logic                     dash_bit;

   assign accept     = in_valid && push_ready;
   assign in_ready   = push_ready;
   assign push_valid = in_valid && (in_mode == stcr_pkg::MODE_STEP);

   // effective thickness and the offset range of its rings
   always_comb begin
      thick_eff  = (6'(ring_thickness_ff) > THICK_LIM) ? THICK_LIM : 6'(ring_thickness_ff);
      half_thick = $signed(OFS_W'(thick_eff >> 1));
      first_ofs  = thick_eff[0] ? -half_thick : (OFS_ONE - half_thick);
      last_ofs   = half_thick;
      last_p1    = last_ofs + OFS_ONE;
   end

   // ring advance with skipping of rings whose radius comes out negative
   always_comb begin
      walking  = active_ff && ring_started_ff && (walk_y_ff >= walk_x_ff);
      ring_end = active_ff && ring_started_ff && !(walk_y_ff >= walk_x_ff);
      ofs_a    = ring_end ? (ring_offset_ff + OFS_ONE) : ring_offset_ff;
      r_try    = $signed(WALK_W'(base_radius_ff)) + WALK_W'(ofs_a);
      neg_base = -$signed(OFS_W'(base_radius_ff));
      if ((ofs_a <= last_ofs) && (r_try < $signed(WALK_W'(0)))) begin
         ofs_b = (neg_base < last_p1) ? neg_base : last_p1;
      end else begin
         ofs_b = ofs_a;
      end
      ring_ok = (ofs_b <= last_ofs);
      r_ring  = $signed(WALK_W'(base_radius_ff)) + WALK_W'(ofs_b);
      d_init  = DEC_INIT - (DEC_W'(r_ring) <<< 1);
   end

   // one column of the midpoint walk
   always_comb begin
      dec_pos = (decision_ff > DEC_ZERO);
      x_nx    = walk_x_ff + WALK_ONE;
      y_nx    = dec_pos ? (walk_y_ff - WALK_ONE) : walk_y_ff;
      xs      = DEC_W'(x_nx);
      ys      = DEC_W'(y_nx);
      d_nx    = dec_pos ? (decision_ff + ((xs - ys) <<< 2) + DEC_TEN)
                        : (decision_ff + (xs <<< 2) + DEC_SIX);
   end

   // dash mask lookup, index wraps at the effective length
   always_comb begin
      len_eff = LEN_W'(dash_length_ff);
      if (len_eff == '0) begin
         len_eff = LEN_ONE;
      end
      if (len_eff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end
      idx_eff  = (LEN_W'(dash_index_ff) >= len_eff) ? '0 : LEN_W'(dash_index_ff);
      dash_bit = (idx_eff < PAT_BITS) ? dash_pattern_ff[idx_eff[4:0]] : 1'b0;
      idx_inc  = idx_eff + LEN_ONE;
      idx_nx   = (idx_inc >= len_eff) ? '0 : idx_inc;
   end

   // settings writes
   always_comb begin
      dash_pattern_in   = dash_pattern_ff;
      dash_length_in    = dash_length_ff;
      ring_thickness_in = ring_thickness_ff;
      if (csr_write.en) begin
         case (csr_write.index)
            stcr_pkg::CSR_DASH_PATTERN: begin
               dash_pattern_in = csr_write.data;
            end
            stcr_pkg::CSR_DASH_LENGTH: begin
               dash_length_in = csr_write.data[stcr_pkg::DASH_LEN_W-1:0];
            end
            stcr_pkg::CSR_RING_THICKNESS: begin
               ring_thickness_in = csr_write.data[stcr_pkg::THICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // state update and job build
   always_comb begin
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      base_radius_in  = base_radius_ff;
      ring_offset_in  = ring_offset_ff;
      walk_x_in       = walk_x_ff;
      walk_y_in       = walk_y_ff;
      decision_in     = decision_ff;
      dash_index_in   = dash_index_ff;
      ring_started_in = ring_started_ff;
      active_in       = active_ff;

      push_job          = '0;
      push_job.center_x = center_x_ff;
      push_job.center_y = center_y_ff;

      if (walking) begin
         push_job.walk_x  = stcr_pkg::POINT_W'(x_nx);
         push_job.walk_y  = stcr_pkg::POINT_W'(y_nx);
         push_job.visible = dash_bit;
      end else if (active_ff && ring_ok) begin
         push_job.walk_x  = '0;
         push_job.walk_y  = stcr_pkg::POINT_W'(r_ring);
         push_job.visible = 1'b1;
      end else begin
         push_job.done = 1'b1;
      end

      if (accept) begin
         if (in_mode == stcr_pkg::MODE_LOAD) begin
            center_x_in     = in_center_x;
            center_y_in     = in_center_y;
            base_radius_in  = in_radius;
            ring_offset_in  = first_ofs;
            walk_x_in       = '0;
            walk_y_in       = '0;
            decision_in     = '0;
            dash_index_in   = '0;
            ring_started_in = 1'b0;
            active_in       = 1'b1;
         end else if (walking) begin
            walk_x_in     = x_nx;
            walk_y_in     = y_nx;
            decision_in   = d_nx;
            dash_index_in = DIDX_W'(idx_nx);
         end else if (active_ff) begin
            ring_offset_in  = ofs_b;
            ring_started_in = ring_ok;
            active_in       = ring_ok;
            if (ring_ok) begin
               walk_x_in     = '0;
               walk_y_in     = r_ring;
               decision_in   = d_init;
               dash_index_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_pattern_ff   <= '1;
         dash_length_ff    <= stcr_pkg::DASH_LEN_W'(1);
         ring_thickness_ff <= stcr_pkg::THICK_W'(1);
         ring_started_ff   <= 1'b0;
         active_ff         <= 1'b0;
      end else begin
         dash_pattern_ff   <= dash_pattern_in;
         dash_length_ff    <= dash_length_in;
         ring_thickness_ff <= ring_thickness_in;
         ring_started_ff   <= ring_started_in;
         active_ff         <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         base_radius_ff <= '0;
         ring_offset_ff <= '0;
         walk_x_ff      <= '0;
         walk_y_ff      <= '0;
         decision_ff    <= '0;
         dash_index_ff  <= '0;
      end else begin
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         base_radius_ff <= base_radius_in;
         ring_offset_ff <= ring_offset_in;
         walk_x_ff      <= walk_x_in;
         walk_y_ff      <= walk_y_in;
         decision_ff    <= decision_in;
         dash_index_ff  <= dash_index_in;
      end
   end

endmodule

// ===== hw/rtl/stcr_queue.sv =====
// ----------------------------------------------------------------------------
// stcr queue
// short job fifo between the step front and the point serializer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  stcr_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output stcr_pkg::job_type pop_job
);

   stcr_pkg::job_type                 mem_ff [stcr_pkg::QUEUE_DEPTH];
   logic [stcr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [stcr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [stcr_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != stcr_pkg::QCNT_W'(stcr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + stcr_pkg::QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + stcr_pkg::QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + stcr_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - stcr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/stcr_back.sv =====
// ----------------------------------------------------------------------------
// stcr back
// walks the eight octant mirrors of a job into a registered result stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stcr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  stcr_pkg::job_type             pop_job,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [stcr_pkg::POINT_W-1:0]  out_point_x,
   output logic [stcr_pkg::POINT_W-1:0]  out_point_y,
   output logic                          out_visible,
   output logic                          out_last,
   output logic                          out_done
);

   logic [stcr_pkg::MIRROR_W-1:0] phase_ff, phase_in;
   logic                          valid_ff, valid_in;
   logic [stcr_pkg::POINT_W-1:0]  point_x_ff, point_x_in;
   logic [stcr_pkg::POINT_W-1:0]  point_y_ff, point_y_in;
   logic                          visible_ff, visible_in;
   logic                          last_ff, last_in;
   logic                          done_ff, done_in;

   logic                          out_free;
   logic                          load;
   logic                          job_end;
   logic [stcr_pkg::POINT_W-1:0]  cx;
   logic [stcr_pkg::POINT_W-1:0]  cy;
   logic [stcr_pkg::POINT_W-1:0]  a;
   logic [stcr_pkg::POINT_W-1:0]  b;

   assign out_free  = !valid_ff || out_ready;
   assign load      = out_free && pop_valid;
   assign job_end   = pop_job.done || (phase_ff == stcr_pkg::MIRROR_LAST);
   assign pop_ready = out_free && job_end;

   // phase bit 2 swaps the axes, bit 1 negates y, bit 0 negates x
   always_comb begin
      cx = stcr_pkg::POINT_W'($signed(pop_job.center_x));
      cy = stcr_pkg::POINT_W'($signed(pop_job.center_y));
      a  = phase_ff[2] ? pop_job.walk_y : pop_job.walk_x;
      b  = phase_ff[2] ? pop_job.walk_x : pop_job.walk_y;
   end

   always_comb begin
      phase_in   = phase_ff;
      valid_in   = valid_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      visible_in = visible_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      if (out_free) begin
         valid_in = load;
      end
      if (load) begin
         if (pop_job.done) begin
            point_x_in = '0;
            point_y_in = '0;
            visible_in = 1'b0;
            last_in    = 1'b1;
            done_in    = 1'b1;
         end else begin
            point_x_in = phase_ff[0] ? (cx - a) : (cx + a);
            point_y_in = phase_ff[1] ? (cy - b) : (cy + b);
            visible_in = pop_job.visible;
            last_in    = (phase_ff == stcr_pkg::MIRROR_LAST);
            done_in    = 1'b0;
         end
         phase_in = job_end ? stcr_pkg::MIRROR_FIRST
                            : (phase_ff + stcr_pkg::MIRROR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stcr_pkg::MIRROR_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      visible_ff <= visible_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
   end

   assign out_valid   = valid_ff;
   assign out_point_x = point_x_ff;
   assign out_point_y = point_y_ff;
   assign out_visible = visible_ff;
   assign out_last    = last_ff;
   assign out_done    = done_ff;

endmodule

// ===== hw/rtl/styled_thick_circle_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// styled thick circle rasterizer unit
// dashed, thick midpoint circle drawer with a stream in and a stream out
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) stores center and radius and restarts the
// figure; it yields no result. Each step transaction (tuser 1) advances the
// midpoint walk of the current ring by one column and yields the eight
// octant-mirrored points of that column, the eighth with tlast; once every
// ring is drawn a step yields a single result with tuser (figure done) and
// tlast set. Rings run from the innermost offset outward, each ring's first
// column is always visible and later columns follow the dash pattern, which
// restarts for every ring. The front accepts a transaction every cycle while
// its two-entry job queue has room; the point serializer behind it puts out
// one result per cycle while the result channel is ready and a job is queued.
// Settings are taken at any time on the csr channel and read live by every
// step; there is no clearing pass after reset.
`timescale 1ns / 1ps
`include "styled_thick_circle_rasterizer_unit_macros.svh"

module styled_thick_circle_rasterizer_unit #(
   parameter int DASH_MAX    = 32,
   parameter int THICK_MAX   = 16,
   parameter int RADIUS_BITS = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [stcr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [stcr_pkg::CSR_DATA_W-1:0]         csr_data,
   // input items
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // center_x[11:0], center_y[23:12], radius, zero fill to whole bytes
   input  logic [((24 + RADIUS_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic                                    req_tuser,
   // result items
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // point_x[12:0], point_y[25:13], visible[26], zero fill [31:27]
   output logic [31:0]                             rsp_tdata,
   // last_of_step
   output logic                                    rsp_tlast,
   // figure_done
   output logic                                    rsp_tuser
);

   stcr_pkg::csr_write_type      csr_write;
   stcr_pkg::job_type            push_job;
   stcr_pkg::job_type            pop_job;
   logic                         push_valid;
   logic                         push_ready;
   logic                         pop_valid;
   logic                         pop_ready;
   logic [stcr_pkg::POINT_W-1:0] point_x;
   logic [stcr_pkg::POINT_W-1:0] point_y;
   logic                         visible;

   // settings are always accepted
   assign csr_ready = 1'b1;
   assign csr_write = '{en: csr_valid && csr_ready, index: csr_index, data: csr_data};

   // front: settings, walk state, one job per step transaction
   stcr_front #(
      .DASH_MAX    (DASH_MAX),
      .THICK_MAX   (THICK_MAX),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tuser),
      .in_center_x (req_tdata[11:0]),
      .in_center_y (req_tdata[23:12]),
      .in_radius   (req_tdata[24 +: RADIUS_BITS]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   // job queue decouples step acceptance from point output
   stcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // back: eight mirrored points per column job, or one done result, into the output register
   stcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_point_x (point_x),
      .out_point_y (point_y),
      .out_visible (visible),
      .out_last    (rsp_tlast),
      .out_done    (rsp_tuser)
   );

   assign rsp_tdata = {5'b0, visible, point_y, point_x};

   // a done answer is a single, masked result
   `STCR_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && !visible, "done result without tlast or with visible set")

   // output drains when the queue behind it is empty
   `STCR_ASSERT_NEXT(a_drain_empty, clock, reset, rsp_tvalid && rsp_tready && !pop_valid, !rsp_tvalid, "result shown with no job queued")

   // an idle block shows a step's first result once its job has passed the queue and the output register
   `STCR_ASSERT_IMPLY(a_step_latency, clock, reset, req_tvalid && req_tready && req_tuser && !rsp_tvalid && !pop_valid, ##2 rsp_tvalid, "step result missing after two cycles")

endmodule
